// ===== hdl/mtc_pkg.sv =====
// ============================================================================
// Magnetometer trim compensation package
// Register indexes and fixed widths shared by the compensation datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mtc_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_TRIM_X_PAIR   = 3'd0,
        REG_TRIM_Y_PAIR   = 3'd1,
        REG_TRIM_XY_PAIR  = 3'd2,
        REG_TRIM_Z_ONE    = 3'd3,
        REG_TRIM_Z_TWO    = 3'd4,
        REG_TRIM_Z_THREE  = 3'd5,
        REG_TRIM_Z_FOUR   = 3'd6,
        REG_TRIM_HALL_REF = 3'd7
    } cfg_reg_t;

    // Divider geometry: a 33-bit dividend covers the z numerator magnitude,
    // a 17-bit divisor covers the z denominator magnitude.
    localparam int unsigned DIV_NUM_W  = 33;
    localparam int unsigned DIV_DEN_W  = 17;
    // Side data carried along the z divider: raw x, raw y, raw z, hall,
    // z guard and z quotient sign.
    localparam int unsigned Z_SIDE_W   = 57;

    // Value forced onto a guarded axis.
    localparam logic [15:0] GUARD_FIELD = 16'h8000;

endpackage

`default_nettype wire

// ===== hdl/mtc_div.sv =====
// ============================================================================
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with side data
// and a valid bit travelling alongside each dividend.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mtc_div #(
    parameter int unsigned NUM_W  = 33,
    parameter int unsigned DEN_W  = 17,
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       quo,
    output logic [SIDE_W-1:0]      side_out
);

    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  nq_reg   [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [NUM_W-1:0]  vld_reg;

    logic [DEN_W-1:0]  rem_next  [NUM_W];
    logic [NUM_W-1:0]  nq_next   [NUM_W];
    logic [DEN_W-1:0]  den_next  [NUM_W];
    logic [SIDE_W-1:0] side_next [NUM_W];
    logic [NUM_W-1:0]  vld_next;

    // One shift-and-subtract step per stage. The dividend shifts out of the
    // top of nq while quotient bits shift in at the bottom.
    always_comb
    begin
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             qbit;
        for (int k = 0; k < NUM_W; k++)
        begin
            if (k == 0)
            begin
                rem_in       = '0;
                nq_in        = num;
                den_in       = den;
                side_next[k] = side;
                vld_next[k]  = in_valid;
            end
            else
            begin
                rem_in       = rem_reg[k-1];
                nq_in        = nq_reg[k-1];
                den_in       = den_reg[k-1];
                side_next[k] = side_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
            end
            trial = {rem_in, nq_in[NUM_W-1]};
            qbit  = (trial >= {1'b0, den_in});
            if (qbit)
            begin
                trial = trial - {1'b0, den_in};
            end
            rem_next[k] = trial[DEN_W-1:0];
            nq_next[k]  = {nq_in[NUM_W-2:0], qbit};
            den_next[k] = den_in;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                nq_reg[k]   <= nq_next[k];
                den_reg[k]  <= den_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quo       = nq_reg[NUM_W-1];
    assign side_out  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

// ===== hdl/magnetometer_trim_compensation.sv =====
// ============================================================================
// Magnetometer trim compensation
// Unpacks one eight-byte magnetometer reading and applies integer trim
// compensation to the x, y and z axes.
// ============================================================================
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[63:0]: the eight raw data bytes of one reading
//  m_axis    out        tdata[111:0]: compensated fields, raw values, guards
//  cfg       in         cfg_we / cfg_index / cfg_data: trim register writes
//
// One beat enters per cycle while m_axis is not stalled. The pipeline is
// the two 33-stage restoring dividers (one quotient bit per stage), plus
// three stages ahead of them and eight behind.
// Reset clears all valid bits and the trim registers; payload is not reset.
// A stall on m_axis freezes every stage at once, and s_tready drops with it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_trim_compensation
    import mtc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // tdata: x_low_byte, x_high_byte, y_low_byte, y_high_byte,
    //        z_low_byte, z_high_byte, hall_low_byte, hall_high_byte
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,
    // tdata: field_x[15:0], field_y[31:16], field_z[47:32], raw_x[60:48],
    //        raw_y[73:61], raw_z[88:74], hall_resistance[102:89],
    //        guard_flags[105:103], zero fill[111:106]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Trim registers
    // ------------------------------------------------------------------
    logic [15:0] trim_x_reg, trim_y_reg, trim_xy_reg, trim_z1_reg;
    logic [15:0] trim_z2_reg, trim_z3_reg, trim_z4_reg;
    logic [14:0] trim_ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_x_reg   <= '0;
            trim_y_reg   <= '0;
            trim_xy_reg  <= '0;
            trim_z1_reg  <= '0;
            trim_z2_reg  <= '0;
            trim_z3_reg  <= '0;
            trim_z4_reg  <= '0;
            trim_ref_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TRIM_X_PAIR:   trim_x_reg   <= cfg_data;
                REG_TRIM_Y_PAIR:   trim_y_reg   <= cfg_data;
                REG_TRIM_XY_PAIR:  trim_xy_reg  <= cfg_data;
                REG_TRIM_Z_ONE:    trim_z1_reg  <= cfg_data;
                REG_TRIM_Z_TWO:    trim_z2_reg  <= cfg_data;
                REG_TRIM_Z_THREE:  trim_z3_reg  <= cfg_data;
                REG_TRIM_Z_FOUR:   trim_z4_reg  <= cfg_data;
                REG_TRIM_HALL_REF: trim_ref_reg <= cfg_data[14:0];
                default:           trim_x_reg   <= trim_x_reg;
            endcase
        end
    end

    // Trim words as the datapath reads them.
    logic signed [7:0]  gain_x, gain_y, off_x, off_y, quad;
    logic        [7:0]  lin;
    logic signed [15:0] z2, z3, z4;

    assign gain_x = $signed(trim_x_reg[7:0]);
    assign off_x  = $signed(trim_x_reg[15:8]);
    assign gain_y = $signed(trim_y_reg[7:0]);
    assign off_y  = $signed(trim_y_reg[15:8]);
    assign quad   = $signed(trim_xy_reg[7:0]);
    assign lin    = trim_xy_reg[15:8];
    assign z2     = $signed(trim_z2_reg);
    assign z3     = $signed(trim_z3_reg);
    assign z4     = $signed(trim_z4_reg);

    // The whole pipeline advances together whenever the output can move.
    logic en;
    logic out_vld_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: unpack, divisor select, z products
    // ------------------------------------------------------------------
    logic signed [12:0] raw_x_c, raw_y_c;
    logic signed [14:0] raw_z_c;
    logic        [13:0] hall_c;
    logic        [14:0] dxy_c;
    logic signed [16:0] dh_c;

    assign raw_x_c = $signed({s_tdata[15:8], s_tdata[7:3]});
    assign raw_y_c = $signed({s_tdata[31:24], s_tdata[23:19]});
    assign raw_z_c = $signed({s_tdata[47:40], s_tdata[39:33]});
    assign hall_c  = {s_tdata[63:56], s_tdata[55:50]};
    assign dxy_c   = (hall_c != '0) ? {1'b0, hall_c} : trim_ref_reg;
    assign dh_c    = $signed({3'b000, hall_c}) - $signed({2'b00, trim_ref_reg});

    logic               v1_reg;
    logic signed [12:0] rx1_reg, ry1_reg;
    logic signed [14:0] rz1_reg;
    logic        [13:0] hall1_reg;
    logic        [14:0] dxy1_reg;
    logic signed [32:0] slp1_reg;
    logic        [29:0] sp1_reg;
    logic signed [16:0] nd1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx1_reg   <= raw_x_c;
            ry1_reg   <= raw_y_c;
            rz1_reg   <= raw_z_c;
            hall1_reg <= hall_c;
            dxy1_reg  <= dxy_c;
            slp1_reg  <= z3 * dh_c;
            sp1_reg   <= trim_z1_reg * hall_c;
            nd1_reg   <= 17'(raw_z_c) - 17'(z4);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: z numerator and denominator
    // ------------------------------------------------------------------
    logic signed [32:0] slp_adj_c;
    logic signed [33:0] numer_c;
    logic        [31:0] sc_c;
    logic signed [17:0] den_c;

    assign slp_adj_c = slp1_reg + (slp1_reg[32] ? 33'sd3 : 33'sd0);
    assign numer_c   = (34'(nd1_reg) <<< 15) - 34'(slp_adj_c >>> 2);
    assign sc_c      = {1'b0, sp1_reg, 1'b0} + 32'd32768;
    assign den_c     = 18'(z2) + $signed({2'b00, sc_c[31:16]});

    logic               v2_reg;
    logic signed [12:0] rx2_reg, ry2_reg;
    logic signed [14:0] rz2_reg;
    logic        [13:0] hall2_reg;
    logic        [14:0] dxy2_reg;
    logic signed [33:0] numer2_reg;
    logic signed [17:0] den2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx2_reg    <= rx1_reg;
            ry2_reg    <= ry1_reg;
            rz2_reg    <= rz1_reg;
            hall2_reg  <= hall1_reg;
            dxy2_reg   <= dxy1_reg;
            numer2_reg <= numer_c;
            den2_reg   <= den_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitudes, quotient sign and divide-by-zero guards
    // ------------------------------------------------------------------
    logic [33:0] an_c;
    logic [17:0] ad_c;

    assign an_c = numer2_reg[33] ? 34'(-numer2_reg) : 34'(numer2_reg);
    assign ad_c = den2_reg[17] ? 18'(-den2_reg) : 18'(den2_reg);

    logic               v3_reg;
    logic signed [12:0] rx3_reg, ry3_reg;
    logic signed [14:0] rz3_reg;
    logic        [13:0] hall3_reg;
    logic        [14:0] dxy3_reg;
    logic               gxy3_reg, gz3_reg, zsg3_reg;
    logic [DIV_NUM_W-1:0] an3_reg;
    logic [DIV_DEN_W-1:0] ad3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx3_reg   <= rx2_reg;
            ry3_reg   <= ry2_reg;
            rz3_reg   <= rz2_reg;
            hall3_reg <= hall2_reg;
            dxy3_reg  <= dxy2_reg;
            gxy3_reg  <= (dxy2_reg == '0);
            gz3_reg   <= (den2_reg == '0);
            zsg3_reg  <= numer2_reg[33] ^ den2_reg[17];
            an3_reg   <= an_c[DIV_NUM_W-1:0];
            ad3_reg   <= ad_c[DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Dividers: hall ratio for x and y, compensated z
    // ------------------------------------------------------------------
    logic                 vxy, vz;
    logic [DIV_NUM_W-1:0] qxy, qz;
    logic                 gxy_d;
    logic [Z_SIDE_W-1:0]  zside_in, zside_d;

    assign zside_in = {rx3_reg, ry3_reg, rz3_reg, hall3_reg, gz3_reg, zsg3_reg};

    mtc_div #(
        .NUM_W  (DIV_NUM_W),
        .DEN_W  (DIV_DEN_W),
        .SIDE_W (1)
    ) u_div_xy (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .num       ({4'b0000, trim_ref_reg, 14'b0}),
        .den       ({2'b00, dxy3_reg}),
        .side      (gxy3_reg),
        .out_valid (vxy),
        .quo       (qxy),
        .side_out  (gxy_d)
    );

    mtc_div #(
        .NUM_W  (DIV_NUM_W),
        .DEN_W  (DIV_DEN_W),
        .SIDE_W (Z_SIDE_W)
    ) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .num       (an3_reg),
        .den       (ad3_reg),
        .side      (zside_in),
        .out_valid (vz),
        .quo       (qz),
        .side_out  (zside_d)
    );

    logic signed [12:0] rx_d, ry_d;
    logic signed [14:0] rz_d;
    logic        [13:0] hall_d;
    logic               gz_d, zsg_d;

    assign {rx_d, ry_d, rz_d, hall_d, gz_d, zsg_d} = zside_d;

    // ------------------------------------------------------------------
    // Stage A: hall ratio, its square and linear term; finish z
    // ------------------------------------------------------------------
    logic signed [15:0] r_c;
    logic        [15:0] zq_c;
    logic        [15:0] fz_c;

    assign r_c  = $signed(qxy[15:0] - 16'h4000);
    assign zq_c = qz[19:4];
    assign fz_c = gz_d ? GUARD_FIELD : (zsg_d ? (16'd0 - zq_c) : zq_c);

    logic               va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg;
    logic signed [31:0] rr_a_reg;
    logic signed [24:0] t6_a_reg;

    // Side data from stage A to the output: raw values, hall, guards, z field.
    logic signed [12:0] rx_reg [7];
    logic signed [12:0] ry_reg [7];
    logic signed [14:0] rz_reg [7];
    logic        [13:0] hl_reg [7];
    logic        [2:0]  gd_reg [7];
    logic        [15:0] fz_reg [7];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_a_reg <= r_c * r_c;
            t6_a_reg <= r_c * $signed({1'b0, lin});
            rx_reg[0] <= rx_d;
            ry_reg[0] <= ry_d;
            rz_reg[0] <= rz_d;
            hl_reg[0] <= hall_d;
            gd_reg[0] <= {gz_d, gxy_d, gxy_d};
            fz_reg[0] <= fz_c;
            for (int k = 1; k < 7; k++)
            begin
                rx_reg[k] <= rx_reg[k-1];
                ry_reg[k] <= ry_reg[k-1];
                rz_reg[k] <= rz_reg[k-1];
                hl_reg[k] <= hl_reg[k-1];
                gd_reg[k] <= gd_reg[k-1];
                fz_reg[k] <= fz_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: quadratic term
    // ------------------------------------------------------------------
    logic signed [32:0] t4_b_reg;
    logic signed [24:0] t6_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t4_b_reg <= quad * $signed({1'b0, rr_a_reg[30:7]});
            t6_b_reg <= t6_a_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: shared sensitivity term
    // ------------------------------------------------------------------
    logic signed [33:0] sum_c, sum_adj_c;

    assign sum_c     = 34'(t4_b_reg) + (34'(t6_b_reg) <<< 7);
    assign sum_adj_c = sum_c + (sum_c[33] ? 34'sd511 : 34'sd0);

    logic signed [25:0] t7_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t7_c_reg <= 26'(sum_adj_c >>> 9) + 26'sd1048576;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: gain scaling per axis
    // ------------------------------------------------------------------
    logic signed [9:0] gmx_c, gmy_c;

    assign gmx_c = 10'(gain_x) + 10'sd160;
    assign gmy_c = 10'(gain_y) + 10'sd160;

    logic signed [35:0] px_d_reg, py_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_d_reg <= t7_c_reg * gmx_c;
            py_d_reg <= t7_c_reg * gmy_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: truncate the gain product
    // ------------------------------------------------------------------
    logic signed [35:0] px_adj_c, py_adj_c;

    assign px_adj_c = px_d_reg + (px_d_reg[35] ? 36'sd4095 : 36'sd0);
    assign py_adj_c = py_d_reg + (py_d_reg[35] ? 36'sd4095 : 36'sd0);

    logic signed [23:0] t9x_e_reg, t9y_e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t9x_e_reg <= 24'(px_adj_c >>> 12);
            t9y_e_reg <= 24'(py_adj_c >>> 12);
        end
    end

    // ------------------------------------------------------------------
    // Stage F: apply to the raw axis values
    // ------------------------------------------------------------------
    logic signed [36:0] prx_f_reg, pry_f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prx_f_reg <= rx_reg[4] * t9x_e_reg;
            pry_f_reg <= ry_reg[4] * t9y_e_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: truncate and wrap to 16 bits
    // ------------------------------------------------------------------
    logic signed [36:0] prx_adj_c, pry_adj_c;
    logic signed [36:0] vx_c, vy_c;

    assign prx_adj_c = prx_f_reg + (prx_f_reg[36] ? 37'sd8191 : 37'sd0);
    assign pry_adj_c = pry_f_reg + (pry_f_reg[36] ? 37'sd8191 : 37'sd0);
    assign vx_c      = prx_adj_c >>> 13;
    assign vy_c      = pry_adj_c >>> 13;

    logic signed [15:0] vx_g_reg, vy_g_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_g_reg <= $signed(vx_c[15:0]);
            vy_g_reg <= $signed(vy_c[15:0]);
        end
    end

    // ------------------------------------------------------------------
    // Output stage: offset, final truncation, guard override
    // ------------------------------------------------------------------
    logic signed [16:0] sx_c, sy_c, sx_adj_c, sy_adj_c;
    logic        [15:0] fx_c, fy_c;

    assign sx_c     = 17'(vx_g_reg) + (17'(off_x) <<< 3);
    assign sy_c     = 17'(vy_g_reg) + (17'(off_y) <<< 3);
    assign sx_adj_c = sx_c + (sx_c[16] ? 17'sd15 : 17'sd0);
    assign sy_adj_c = sy_c + (sy_c[16] ? 17'sd15 : 17'sd0);
    assign fx_c     = gd_reg[6][0] ? GUARD_FIELD : 16'(sx_adj_c >>> 4);
    assign fy_c     = gd_reg[6][1] ? GUARD_FIELD : 16'(sy_adj_c >>> 4);

    logic [111:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {6'b0, gd_reg[6], hl_reg[6], rz_reg[6], ry_reg[6],
                             rx_reg[6], fz_reg[6], fy_c, fx_c};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            vc_reg      <= 1'b0;
            vd_reg      <= 1'b0;
            ve_reg      <= 1'b0;
            vf_reg      <= 1'b0;
            vg_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg      <= vz;
            vb_reg      <= va_reg;
            vc_reg      <= vb_reg;
            vd_reg      <= vc_reg;
            ve_reg      <= vd_reg;
            vf_reg      <= ve_reg;
            vg_reg      <= vf_reg;
            out_vld_reg <= vg_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Both dividers carry the same beats in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        vxy == vz)
        else $error("divider valid bits out of step");

    // A guarded x beat always shows the forced field value.
    a_guard_x: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[103] |-> m_tdata[15:0] == GUARD_FIELD)
        else $error("guarded x field not forced");

    // The x and y guards come from one divisor and always agree.
    a_guard_xy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[103] == m_tdata[104])
        else $error("x and y guards disagree");

    // A beat held at the output blocks new input.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

endmodule

`default_nettype wire
